@@ rtl/core/gtr_pkg.sv @@
// Shared types and constants for the guest texture registry.
// No dependencies; the cell, top level, checker and testbench import this package.
package gtr_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 64;
   localparam int KEY_W = 53;
   localparam logic [7:0] OP_A = 8'h2D;
   localparam logic [7:0] OP_B = 8'h36;
   localparam logic [5:0] FMT_RGBA = 6'd6;
   localparam logic [5:0] FMT_RG = 6'd10;
   localparam logic [5:0] FMT_BC = 6'd20;
   localparam logic [31:0] SIXTEEN_MIB = 32'd16777216;

   localparam logic [1:0] ST_HIT = 2'd0;
   localparam logic [1:0] ST_CREATED = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_IGNORED = 2'd3;

   localparam logic [1:0] CS_NEW = 2'd1;
   localparam logic [1:0] CS_RESIDENT = 2'd2;

   localparam logic CMD_FETCH = 1'b0;

   typedef struct packed {
      logic [1:0]  state;
      logic [24:0] bytes;
      logic [1:0]  fmt;
   } info_type;

   typedef struct packed {
      logic              cmd;
      logic [4:0]        slot;
      logic [7:0]        op;
      logic [31:0]       frame;
      logic [31:0]       base;
      logic [31:0]       mip;
      logic [KEY_W-1:0]  key;
   } query_type;

   typedef struct packed {
      logic        active;
      logic        found;
      logic [5:0]  slot;
      logic [31:0] id;
      info_type    info;
   } token_type;

   function automatic logic [1:0] guest_to_host_fmt(input logic [5:0] f);
      logic [1:0] r;
      r = 2'd0;
      if (f == FMT_RGBA) r = 2'd1;
      else if (f == FMT_RG) r = 2'd2;
      else if (f == FMT_BC) r = 2'd3;
      return r;
   endfunction

   // Cache state after a request: a draw use marks an entry with a known size resident.
   function automatic info_type apply_use(input info_type i, input logic cmd);
      info_type r;
      r = i;
      if (cmd != CMD_FETCH && i.bytes != '0) r.state = CS_RESIDENT;
      return r;
   endfunction

endpackage

@@ rtl/core/gtr_req_if.sv @@
// Valid/ready channel interface for requests into the texture registry.
// Depends on nothing.
interface gtr_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [4:0]  fetch_slot;
   logic [7:0]  draw_opcode;
   logic [31:0] base_address;
   logic [31:0] mip_address;
   logic [13:0] tex_width;
   logic [13:0] tex_height;
   logic [5:0]  tex_format;
   logic [1:0]  tex_dimension;
   logic [15:0] row_pitch;
   logic        is_tiled;
   logic [31:0] frame_number;

   modport source(output valid, command, fetch_slot, draw_opcode, base_address, mip_address,
                  tex_width, tex_height, tex_format, tex_dimension, row_pitch, is_tiled,
                  frame_number, input ready);
   modport sink(input valid, command, fetch_slot, draw_opcode, base_address, mip_address,
                tex_width, tex_height, tex_format, tex_dimension, row_pitch, is_tiled,
                frame_number, output ready);
endinterface

// Valid/ready channel interface for results out of the texture registry.
interface gtr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] cache_id;
   logic [5:0]  entry_slot_index;
   logic [1:0]  host_fmt;
   logic [24:0] byte_estimate;
   logic [1:0]  cache_status;

   modport source(output valid, status, cache_id, entry_slot_index, host_fmt, byte_estimate,
                  cache_status, input ready);
   modport sink(input valid, status, cache_id, entry_slot_index, host_fmt, byte_estimate,
                cache_status, output ready);
endinterface

@@ rtl/core/gtr_cell.sv @@
// One table entry of the registry chain: stores the entry and compares the passing search token.
// Depends on gtr_pkg.
module gtr_cell #(
   parameter int IDX = 0,
   parameter int IW = 6,
   parameter int UW = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gtr_pkg::query_type   query,
   input  logic [UW-1:0]        used,
   input  logic                 wr_en,
   input  logic [IW-1:0]        wr_idx,
   input  logic [31:0]          wr_id,
   input  gtr_pkg::info_type    wr_info,
   input  gtr_pkg::token_type   tok_in,
   output gtr_pkg::token_type   tok_out
);
   import gtr_pkg::*;

   logic [31:0]      base_ff, mip_ff, id_ff;
   logic [KEY_W-1:0] key_ff;
   logic [4:0]       first_slot_ff, last_slot_ff;
   logic [31:0]      first_frame_ff, last_frame_ff;
   logic [31:0]      fetches_ff, hits_ff, draws_ff, others_ff, op_a_ff, op_b_ff;
   info_type         info_ff;
   token_type        tok_ff, tok_in_w;

   logic     hit, create, upd;
   info_type info_base, info_in;
   logic [31:0] fetches_in, hits_in, draws_in, others_in, op_a_in, op_b_in;

   assign hit = tok_in.active && !tok_in.found && (used > UW'(IDX)) &&
                base_ff == query.base && mip_ff == query.mip && key_ff == query.key;
   assign create = wr_en && wr_idx == IW'(IDX);
   assign upd = hit || create;

   always_comb begin
      info_base = create ? wr_info : info_ff;
      info_in = apply_use(info_base, query.cmd);
      fetches_in = create ? 32'd0 : fetches_ff;
      hits_in = (create ? 32'd0 : hits_ff) + 32'd1;
      draws_in = create ? 32'd0 : draws_ff;
      others_in = create ? 32'd0 : others_ff;
      op_a_in = create ? 32'd0 : op_a_ff;
      op_b_in = create ? 32'd0 : op_b_ff;
      if (query.cmd == CMD_FETCH) begin
         fetches_in = fetches_in + 32'd1;
      end else begin
         draws_in = draws_in + 32'd1;
         if (query.op == OP_A) op_a_in = op_a_in + 32'd1;
         else if (query.op == OP_B) op_b_in = op_b_in + 32'd1;
         else others_in = others_in + 32'd1;
      end
      tok_in_w = tok_in;
      if (hit) begin
         tok_in_w.found = 1'b1;
         tok_in_w.slot = 6'(IDX);
         tok_in_w.id = id_ff;
         tok_in_w.info = info_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff.active <= tok_in_w.active;
      end
      tok_ff.found <= tok_in_w.found;
      tok_ff.slot <= tok_in_w.slot;
      tok_ff.id <= tok_in_w.id;
      tok_ff.info <= tok_in_w.info;
      if (create) begin
         base_ff <= query.base;
         mip_ff <= query.mip;
         key_ff <= query.key;
         id_ff <= wr_id;
         first_slot_ff <= query.slot;
         first_frame_ff <= query.frame;
      end
      if (upd) begin
         last_slot_ff <= query.slot;
         last_frame_ff <= query.frame;
         info_ff <= info_in;
         fetches_ff <= fetches_in;
         hits_ff <= hits_in;
         draws_ff <= draws_in;
         others_ff <= others_in;
         op_a_ff <= op_a_in;
         op_b_ff <= op_b_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

@@ rtl/core/guest_texture_registry_top.sv @@
// Guest texture registry top level: request control, size estimate and a chain of entry cells.
// Each request is registered, then passes through the calculation, search and done states;
// an ignored request skips straight to the done state. One request is in flight at a time.
// The search token walks the cell chain one entry per cycle, registered in each cell.
// Reset empties the table and restarts cache ids at 1; entry contents are not cleared.
// Depends on gtr_pkg, gtr_req_if, gtr_rsp_if and gtr_cell.
module guest_texture_registry_top #(
   parameter int TABLE_DEPTH = gtr_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   gtr_req_if.sink  req_ch,
   gtr_rsp_if.source rsp_ch
);
   import gtr_pkg::*;

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int UW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {S_IDLE, S_CALC, S_SCAN, S_DONE} state_type;

   state_type   state_ff;
   query_type   query_ff;
   logic [13:0] w_ff, h_ff;
   logic [5:0]  fmt_ff;
   logic        invalid_ff;
   logic [27:0] prod_ff;
   logic [24:0] est_ff;
   logic        found_ff;
   token_type   res_ff;
   logic [UW-1:0] used_ff;
   logic [31:0] next_id_ff;

   logic        rsp_valid_ff;
   logic [1:0]  status_ff, host_fmt_ff, cache_status_ff;
   logic [31:0] cache_id_ff;
   logic [5:0]  slot_idx_ff;
   logic [24:0] bytes_ff;

   logic [1:0]  status_in, host_fmt_in, cache_status_in;
   logic [31:0] cache_id_in;
   logic [5:0]  slot_idx_in;
   logic [24:0] bytes_in;

   token_type   chain [TABLE_DEPTH+1];
   token_type   inject;
   logic        accept, finish, full, wr_en;
   logic [12:0] wq, hq;
   logic [27:0] prod_in;
   logic [31:0] b, gap;
   logic [24:0] est_in;
   info_type    new_info, created_info;

   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign finish = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);
   assign full = (used_ff >= UW'(TABLE_DEPTH));
   assign wr_en = finish && !invalid_ff && !found_ff && !full;

   always_comb begin
      wq = 13'((15'(w_ff) + 15'd3) >> 2);
      hq = 13'((15'(h_ff) + 15'd3) >> 2);
      if (fmt_ff == FMT_BC) prod_in = 28'(wq) * 28'(hq);
      else prod_in = 28'(w_ff) * 28'(h_ff);
      if (fmt_ff == FMT_BC) b = {prod_ff, 4'd0};
      else if (fmt_ff == FMT_RG) b = {3'd0, prod_ff, 1'b0};
      else b = {2'd0, prod_ff[27:0], 2'd0};
      gap = query_ff.mip - query_ff.base;
      if (query_ff.mip > query_ff.base && gap <= SIXTEEN_MIB) est_in = gap[24:0];
      else if (b == 32'd0 || b > SIXTEEN_MIB) est_in = '0;
      else est_in = b[24:0];
      new_info.fmt = guest_to_host_fmt(fmt_ff);
      new_info.bytes = est_ff;
      new_info.state = CS_NEW;
      created_info = apply_use(new_info, query_ff.cmd);
      inject = '0;
      inject.active = (state_ff == S_CALC);
   end

   always_comb begin
      status_in = ST_HIT;
      cache_id_in = '0;
      slot_idx_in = '0;
      host_fmt_in = '0;
      bytes_in = '0;
      cache_status_in = '0;
      if (invalid_ff) begin
         status_in = ST_IGNORED;
      end else if (found_ff) begin
         cache_id_in = res_ff.id;
         slot_idx_in = res_ff.slot;
         host_fmt_in = res_ff.info.fmt;
         bytes_in = res_ff.info.bytes;
         cache_status_in = res_ff.info.state;
      end else if (full) begin
         status_in = ST_FULL;
      end else begin
         status_in = ST_CREATED;
         cache_id_in = next_id_ff;
         slot_idx_in = 6'(used_ff);
         host_fmt_in = created_info.fmt;
         bytes_in = created_info.bytes;
         cache_status_in = created_info.state;
      end
   end

   assign chain[0] = inject;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      gtr_cell #(.IDX(i), .IW(IW), .UW(UW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .query   (query_ff),
         .used    (used_ff),
         .wr_en   (wr_en),
         .wr_idx  (used_ff[IW-1:0]),
         .wr_id   (next_id_ff),
         .wr_info (new_info),
         .tok_in  (chain[i]),
         .tok_out (chain[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         next_id_ff <= 32'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (finish) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= (req_ch.base_address == '0 || req_ch.tex_width == '0 ||
                               req_ch.tex_height == '0) ? S_DONE : S_CALC;
               end
            end
            S_CALC: state_ff <= S_SCAN;
            S_SCAN: begin
               if (chain[TABLE_DEPTH].active) state_ff <= S_DONE;
            end
            S_DONE: begin
               if (finish) begin
                  state_ff <= S_IDLE;
                  if (wr_en) begin
                     used_ff <= used_ff + UW'(1);
                     next_id_ff <= next_id_ff + 32'd1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
      if (accept) begin
         query_ff.cmd <= req_ch.command;
         query_ff.slot <= req_ch.fetch_slot;
         query_ff.op <= req_ch.draw_opcode;
         query_ff.frame <= req_ch.frame_number;
         query_ff.base <= req_ch.base_address;
         query_ff.mip <= req_ch.mip_address;
         query_ff.key <= {req_ch.is_tiled, req_ch.row_pitch, req_ch.tex_dimension,
                          req_ch.tex_format, req_ch.tex_height, req_ch.tex_width};
         w_ff <= req_ch.tex_width;
         h_ff <= req_ch.tex_height;
         fmt_ff <= req_ch.tex_format;
         invalid_ff <= (req_ch.base_address == '0 || req_ch.tex_width == '0 ||
                        req_ch.tex_height == '0);
         found_ff <= 1'b0;
      end
      if (state_ff == S_CALC) prod_ff <= prod_in;
      if (state_ff == S_SCAN) begin
         est_ff <= est_in;
         res_ff <= chain[TABLE_DEPTH];
         found_ff <= chain[TABLE_DEPTH].found;
      end
      if (finish) begin
         status_ff <= status_in;
         cache_id_ff <= cache_id_in;
         slot_idx_ff <= slot_idx_in;
         host_fmt_ff <= host_fmt_in;
         bytes_ff <= bytes_in;
         cache_status_ff <= cache_status_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = status_ff;
   assign rsp_ch.cache_id = cache_id_ff;
   assign rsp_ch.entry_slot_index = slot_idx_ff;
   assign rsp_ch.host_fmt = host_fmt_ff;
   assign rsp_ch.byte_estimate = bytes_ff;
   assign rsp_ch.cache_status = cache_status_ff;

endmodule

@@ rtl/core/gtr_checker.sv @@
// Port-level checks for the guest texture registry, bound to the top level.
// Depends on gtr_pkg and guest_texture_registry_top.
module gtr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  status,
   input logic [31:0] cache_id,
   input logic [5:0]  slot_index,
   input logic [24:0] byte_estimate,
   input logic [1:0]  cache_status
);
   import gtr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(cache_id))
      else $error("Result changed while stalled.");

   a_no_entry_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == ST_FULL || status == ST_IGNORED) |->
      cache_id == '0 && slot_index == '0 && byte_estimate == '0 && cache_status == '0)
      else $error("Request without an entry returned entry fields.");

   a_entry_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == ST_HIT || status == ST_CREATED) |->
      cache_status == CS_NEW || cache_status == CS_RESIDENT)
      else $error("Entry result carries no cache state.");

   a_resident_sized: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cache_status == CS_RESIDENT |-> byte_estimate != '0)
      else $error("Resident entry has no size.");

endmodule

bind guest_texture_registry_top gtr_checker u_gtr_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .status        (rsp_ch.status),
   .cache_id      (rsp_ch.cache_id),
   .slot_index    (rsp_ch.entry_slot_index),
   .byte_estimate (rsp_ch.byte_estimate),
   .cache_status  (rsp_ch.cache_status)
);

@@ tb/sv/tb_guest_texture_registry_top.sv @@
// Self-checking testbench for the guest texture registry: directed and random requests,
// with a behavioral table model predicting every result. Depends on gtr_pkg,
// gtr_req_if, gtr_rsp_if and guest_texture_registry_top.
module tb_guest_texture_registry_top;
   import gtr_pkg::*;

   localparam int DEPTH = DEFAULT_TABLE_DEPTH;
   localparam int LIMIT = 2000000;

   typedef struct {
      logic        command;
      logic [4:0]  fetch_slot;
      logic [7:0]  draw_opcode;
      logic [31:0] base_address;
      logic [31:0] mip_address;
      logic [13:0] tex_width;
      logic [13:0] tex_height;
      logic [5:0]  tex_format;
      logic [1:0]  tex_dimension;
      logic [15:0] row_pitch;
      logic        is_tiled;
      logic [31:0] frame_number;
   } texture_req_type;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] cache_id;
      logic [5:0]  entry_slot_index;
      logic [1:0]  host_fmt;
      logic [24:0] byte_estimate;
      logic [1:0]  cache_status;
   } texture_rsp_type;

   logic clock = 0;
   logic reset = 1;
   int   cycle_count = 0;
   int   error_count = 0;
   int   hold_off = 0;

   gtr_req_if req_ch();
   gtr_rsp_if rsp_ch();

   guest_texture_registry_top DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   always #6 clock = ~clock;

   // Table model state.
   int          table_used;
   logic [31:0] id_counter;
   logic [31:0] tbl_base [DEPTH];
   logic [31:0] tbl_mip [DEPTH];
   logic [52:0] tbl_key [DEPTH];
   logic [31:0] tbl_id [DEPTH];
   logic [1:0]  tbl_fmt [DEPTH];
   logic [24:0] tbl_bytes [DEPTH];
   logic [1:0]  tbl_state [DEPTH];
   texture_rsp_type pending_rsp[$];
   texture_req_type known_tex[$];

   function automatic logic [24:0] size_estimate(texture_req_type r);
      logic [63:0] b;
      if (r.mip_address > r.base_address && r.mip_address - r.base_address <= SIXTEEN_MIB)
         return 25'(r.mip_address - r.base_address);
      if (r.tex_format == FMT_BC)
         b = 64'((r.tex_width + 32'd3) / 4) * 64'((r.tex_height + 32'd3) / 4) * 16;
      else if (r.tex_format == FMT_RG)
         b = 64'(r.tex_width) * 64'(r.tex_height) * 2;
      else
         b = 64'(r.tex_width) * 64'(r.tex_height) * 4;
      if (b == 0 || b > SIXTEEN_MIB) return '0;
      return 25'(b);
   endfunction

   function automatic texture_rsp_type predict_lookup(texture_req_type r);
      texture_rsp_type e;
      logic [52:0]  k;
      int           idx;
      e = '{default: '0};
      if (r.base_address == 0 || r.tex_width == 0 || r.tex_height == 0) begin
         e.status = ST_IGNORED;
         return e;
      end
      k = {r.is_tiled, r.row_pitch, r.tex_dimension, r.tex_format, r.tex_height, r.tex_width};
      idx = -1;
      for (int i = 0; i < table_used; i++)
         if (idx < 0 && tbl_base[i] == r.base_address && tbl_mip[i] == r.mip_address &&
             tbl_key[i] == k) idx = i;
      e.status = ST_HIT;
      if (idx < 0) begin
         if (table_used >= DEPTH) begin
            e.status = ST_FULL;
            return e;
         end
         idx = table_used;
         table_used = table_used + 1;
         tbl_base[idx] = r.base_address;
         tbl_mip[idx] = r.mip_address;
         tbl_key[idx] = k;
         tbl_id[idx] = id_counter;
         id_counter = id_counter + 32'd1;
         tbl_fmt[idx] = r.tex_format == FMT_RGBA ? 2'd1 : r.tex_format == FMT_RG ? 2'd2 :
                        r.tex_format == FMT_BC ? 2'd3 : 2'd0;
         tbl_bytes[idx] = size_estimate(r);
         tbl_state[idx] = CS_NEW;
         e.status = ST_CREATED;
      end
      if (r.command != CMD_FETCH && tbl_bytes[idx] != 0) tbl_state[idx] = CS_RESIDENT;
      e.cache_id = tbl_id[idx];
      e.entry_slot_index = 6'(idx);
      e.host_fmt = tbl_fmt[idx];
      e.byte_estimate = tbl_bytes[idx];
      e.cache_status = tbl_state[idx];
      return e;
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   initial begin
      req_ch.valid = 0;
      req_ch.command = 0;
      req_ch.fetch_slot = 0;
      req_ch.draw_opcode = 0;
      req_ch.base_address = 0;
      req_ch.mip_address = 0;
      req_ch.tex_width = 0;
      req_ch.tex_height = 0;
      req_ch.tex_format = 0;
      req_ch.tex_dimension = 0;
      req_ch.row_pitch = 0;
      req_ch.is_tiled = 0;
      req_ch.frame_number = 0;
      rsp_ch.ready = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("tb_guest_texture_registry_top: errors");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off on request.
   initial begin
      int g;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            rsp_ch.ready <= 0;
            hold_off = hold_off - 1;
         end else begin
            g = gap_len();
            if (g > 0) begin
               rsp_ch.ready <= 0;
               repeat (g - 1) @(posedge clock);
               @(posedge clock);
            end
            rsp_ch.ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      texture_rsp_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: result with nothing expected, got status %0d id %0d", $time,
                     rsp_ch.status, rsp_ch.cache_id);
            error_count++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_ch.status !== e.status || rsp_ch.cache_id !== e.cache_id ||
                rsp_ch.entry_slot_index !== e.entry_slot_index ||
                rsp_ch.host_fmt !== e.host_fmt || rsp_ch.byte_estimate !== e.byte_estimate ||
                rsp_ch.cache_status !== e.cache_status) begin
               $display("%0t: expected st %0d id %0d idx %0d fmt %0d bytes %0d cs %0d",
                        $time, e.status, e.cache_id, e.entry_slot_index, e.host_fmt,
                        e.byte_estimate, e.cache_status);
               $display("%0t: actual   st %0d id %0d idx %0d fmt %0d bytes %0d cs %0d",
                        $time, rsp_ch.status, rsp_ch.cache_id, rsp_ch.entry_slot_index,
                        rsp_ch.host_fmt, rsp_ch.byte_estimate, rsp_ch.cache_status);
               error_count++;
            end
         end
      end
   end

   task automatic send_request(texture_req_type r, bit no_gap = 0);
      int g;
      g = no_gap ? 0 : gap_len();
      if (g > 0) begin
         req_ch.valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.command <= r.command;
      req_ch.fetch_slot <= r.fetch_slot;
      req_ch.draw_opcode <= r.draw_opcode;
      req_ch.base_address <= r.base_address;
      req_ch.mip_address <= r.mip_address;
      req_ch.tex_width <= r.tex_width;
      req_ch.tex_height <= r.tex_height;
      req_ch.tex_format <= r.tex_format;
      req_ch.tex_dimension <= r.tex_dimension;
      req_ch.row_pitch <= r.row_pitch;
      req_ch.is_tiled <= r.is_tiled;
      req_ch.frame_number <= r.frame_number;
      pending_rsp.push_back(predict_lookup(r));
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic texture_req_type random_texture();
      texture_req_type r;
      int           p;
      r.command = 1'($urandom_range(0, 1));
      r.fetch_slot = 5'($urandom);
      p = $urandom_range(0, 2);
      r.draw_opcode = p == 0 ? OP_A : p == 1 ? OP_B : 8'($urandom);
      r.base_address = $urandom;
      r.mip_address = $urandom_range(0, 1) ? r.base_address + $urandom_range(0, 32'h0200_0000)
                                           : $urandom;
      r.tex_width = $urandom_range(0, 3) == 0 ? 14'($urandom) : 14'($urandom_range(1, 2048));
      r.tex_height = $urandom_range(0, 3) == 0 ? 14'($urandom) : 14'($urandom_range(1, 2048));
      p = $urandom_range(0, 3);
      r.tex_format = p == 0 ? FMT_RGBA : p == 1 ? FMT_RG : p == 2 ? FMT_BC : 6'($urandom);
      r.tex_dimension = 2'($urandom);
      r.row_pitch = 16'($urandom);
      r.is_tiled = 1'($urandom);
      r.frame_number = $urandom;
      if ($urandom_range(0, 19) == 0) begin
         p = $urandom_range(0, 2);
         if (p == 0) r.base_address = 0;
         else if (p == 1) r.tex_width = 0;
         else r.tex_height = 0;
      end
      return r;
   endfunction

   // Mostly revisits known textures so hits dominate, with fresh ones to grow the table.
   function automatic texture_req_type pick_texture();
      texture_req_type r;
      if (known_tex.size() > 0 && $urandom_range(0, 99) < 70) begin
         r = known_tex[$urandom_range(0, known_tex.size() - 1)];
         r.command = 1'($urandom_range(0, 1));
         r.fetch_slot = 5'($urandom);
         r.draw_opcode = $urandom_range(0, 1) ? OP_A : 8'($urandom);
         if ($urandom_range(0, 3) == 0) r.draw_opcode = OP_B;
         r.frame_number = $urandom;
      end else begin
         r = random_texture();
         if (known_tex.size() < 200) known_tex.push_back(r);
      end
      return r;
   endfunction

   task automatic wait_drained();
      req_ch.valid <= 0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic test_directed();
      texture_req_type r;
      r = '{command: 0, fetch_slot: 0, draw_opcode: 0, base_address: 32'h1000,
            mip_address: 32'h1000, tex_width: 1, tex_height: 1, tex_format: 0,
            tex_dimension: 0, row_pitch: 0, is_tiled: 0, frame_number: 0};
      send_request(r);
      send_request(r);
      r.command = 1; r.draw_opcode = OP_A; send_request(r);
      r.draw_opcode = OP_B; send_request(r);
      r.draw_opcode = 8'hFF; r.fetch_slot = 31; r.frame_number = '1; send_request(r);
      r.base_address = 0; send_request(r);
      r.base_address = '1; r.tex_width = 0; send_request(r);
      r.tex_width = 8192; r.tex_height = 0; send_request(r);
      r.tex_height = 8192; r.mip_address = 0; r.tex_format = FMT_BC; send_request(r);
      r.tex_format = FMT_RG; send_request(r);
      r.tex_format = FMT_RGBA; r.tex_width = 14'h3FFF; r.tex_height = 14'h3FFF;
      send_request(r);
      r.tex_width = 2048; r.tex_height = 2048; r.tex_format = FMT_RGBA; send_request(r);
      r.base_address = 32'h10; r.mip_address = 32'h0100_0010; r.tex_format = 6'h3F;
      r.tex_dimension = 3; r.row_pitch = '1; r.is_tiled = 1; send_request(r);
      r.mip_address = 32'h0100_0011; send_request(r);
      r.command = 0; r.tex_width = 3; r.tex_height = 5; r.tex_format = FMT_BC;
      r.mip_address = 32'h0; send_request(r);
      r.command = 1; r.mip_address = 32'h8; r.base_address = 32'hFFFF_FFF0; send_request(r);
      wait_drained();
   endtask

   task automatic test_backpressure();
      hold_off = 400;
      for (int i = 0; i < 30; i++) send_request(pick_texture(), 1);
      wait_drained();
   endtask

   task automatic test_random_mix();
      for (int i = 0; i < 1300; i++) send_request(pick_texture());
      wait_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      table_used = 0;
      id_counter = 1;
      test_directed();
      test_backpressure();
      test_random_mix();
      if (error_count == 0)
         $display("tb_guest_texture_registry_top: clean");
      else
         $display("tb_guest_texture_registry_top: errors");
      $finish;
   end
endmodule
